// File: rtl/core/srctl_pkg.sv
package srctl_pkg;

	localparam int SLOT_W  = 4;
	localparam int POS_W   = 12;
	localparam int US_W    = 16;
	localparam int CONV_NUM_W = 28;

	localparam logic [POS_W-1:0] MID_COUNTS   = 12'd1791;
	localparam logic [POS_W-1:0] RESET_STEP   = 12'd10;
	localparam logic [POS_W-1:0] RESET_RAMP   = 12'd1;
	localparam logic [POS_W-1:0] RESET_DEADBAND = 12'd3;

	typedef enum logic [1:0] {
		ACT_TICK      = 2'd0,
		ACT_MOVE      = 2'd1,
		ACT_CONFIGURE = 2'd2,
		ACT_TEST      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_SERVO_OFF  = 2'd0,
		REG_SOFT_START = 2'd1,
		REG_DEADBAND   = 2'd2
	} reg_index_t;

	typedef struct packed {
		action_t           action;
		logic [SLOT_W-1:0] servo_index;
		logic              direction;
		logic [US_W-1:0]   straight_us;
		logic [US_W-1:0]   diverted_us;
		logic [US_W-1:0]   rate_us;
	} cmd_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] servo_slot;
		logic [POS_W-1:0]  pulse_value;
		logic              output_off;
		logic [POS_W-1:0]  current_value;
		logic [POS_W-1:0]  target_value;
		logic              moving;
		logic              last;
	} result_item_t;

	typedef struct packed {
		logic [1:0]       index;
		logic [POS_W-1:0] value;
	} cfg_write_t;

	typedef struct packed {
		logic             servo_off_enable;
		logic             soft_start_enable;
		logic [POS_W-1:0] deadband_width;
	} cfg_regs_t;

	// Command broadcast to every cell; only the addressed cell acts on it.
	typedef struct packed {
		logic              apply;
		action_t           action;
		logic [SLOT_W-1:0] servo_index;
		logic              direction;
		logic [POS_W-1:0]  straight_pos;
		logic [POS_W-1:0]  diverted_pos;
		logic [POS_W-1:0]  step_size;
	} cell_cmd_t;

	typedef struct packed {
		logic shift;
		logic advance;
	} chain_ctl_t;

endpackage

// File: rtl/core/srctl_stream_if.sv
interface srctl_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/srctl_div.sv
module srctl_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               is_speed,
	input  logic [srctl_pkg::CONV_NUM_W-1:0]   numer,
	output logic                               done,
	output logic [srctl_pkg::POS_W-1:0]        quot
);

	localparam int NUM_W   = srctl_pkg::CONV_NUM_W;
	localparam int SH_W    = 21;
	localparam int RCP_W   = 22;
	localparam int PRD_W   = SH_W + RCP_W;
	localparam int SHR_POS = 22;
	localparam int SHR_SPD = 31;

	// Positions divide by 1600 = 64 * 25 and speeds by 80000 = 128 * 625. The
	// power-of-two factor is a shift; the odd factor is a multiply by a rounded-up
	// reciprocal, which is exact over the whole range of products fed in here.
	localparam logic [RCP_W-1:0] RCP_POS = 22'd167773;
	localparam logic [RCP_W-1:0] RCP_SPD = 22'd3435974;

	logic [SH_W-1:0]             shifted_s1;
	logic                        speed_s1;
	logic                        valid_s1;
	logic [srctl_pkg::POS_W-1:0] quo_q;
	logic                        done_q;
	logic [PRD_W-1:0]            prod;

	assign prod = PRD_W'(shifted_s1) * PRD_W'(speed_s1 ? RCP_SPD : RCP_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shifted_s1 <= is_speed ? numer[NUM_W-1:7] : numer[SH_W+5:6];
			speed_s1   <= is_speed;
		end
		if (valid_s1) begin
			quo_q <= speed_s1 ? prod[SHR_SPD +: srctl_pkg::POS_W]
				: prod[SHR_POS +: srctl_pkg::POS_W];
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: rtl/core/srctl_cell.sv
module srctl_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srctl_pkg::cfg_regs_t           regs,
	input  srctl_pkg::cell_cmd_t           cmd,
	input  srctl_pkg::chain_ctl_t          ctl,
	input  logic [srctl_pkg::SLOT_W-1:0]   slot_id,
	input  logic                           is_last,
	input  logic                           token_in,
	output logic                           token_out,
	input  srctl_pkg::result_item_t        res_in,
	output srctl_pkg::result_item_t        res_out
);

	localparam int W = srctl_pkg::POS_W;

	logic [W-1:0] straight_q;
	logic [W-1:0] diverted_q;
	logic [W-1:0] step_q;
	logic [W-1:0] cur_q;
	logic [W-1:0] tgt_q;
	logic [W-1:0] ramp_q;
	logic         token_q;

	logic [W-1:0] gap;
	logic         arrived;
	logic [W-1:0] ramp_n;
	logic [W-1:0] step_eff;
	logic [W-1:0] cur_n;
	logic [W-1:0] pulse;
	logic         off;
	logic [W:0]   pos_sum;
	logic [W-1:0] mid;
	logic         hit;
	logic         act;

	assign gap     = (cur_q > tgt_q) ? (cur_q - tgt_q) : (tgt_q - cur_q);
	assign arrived = (gap <= regs.deadband_width);
	assign pos_sum = {1'b0, straight_q} + {1'b0, diverted_q};
	assign mid     = pos_sum[W:1];
	assign hit     = cmd.apply && (cmd.servo_index == slot_id);
	assign act     = ctl.advance && token_q;

	always_comb begin
		ramp_n   = ramp_q;
		step_eff = step_q;
		off      = 1'b0;
		if (arrived) begin
			cur_n = tgt_q;
			off   = regs.servo_off_enable;
			pulse = regs.servo_off_enable ? '0 : tgt_q;
		end else begin
			if (regs.soft_start_enable) begin
				if (ramp_q < step_q) begin
					ramp_n = ramp_q + 1'b1;
				end
				step_eff = ramp_n;
			end
			if (gap <= step_eff) begin
				cur_n = tgt_q;
			end else if (cur_q < tgt_q) begin
				cur_n = cur_q + step_eff;
			end else begin
				cur_n = cur_q - step_eff;
			end
			pulse = cur_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_q <= srctl_pkg::MID_COUNTS;
			diverted_q <= srctl_pkg::MID_COUNTS;
			step_q     <= srctl_pkg::RESET_STEP;
			cur_q      <= srctl_pkg::MID_COUNTS;
			tgt_q      <= srctl_pkg::MID_COUNTS;
			ramp_q     <= srctl_pkg::RESET_RAMP;
			token_q    <= 1'b0;
		end else begin
			if (ctl.shift) begin
				token_q <= token_in;
			end
			if (act) begin
				cur_q  <= cur_n;
				ramp_q <= ramp_n;
			end else if (hit) begin
				ramp_q <= srctl_pkg::RESET_RAMP;
				case (cmd.action)
					srctl_pkg::ACT_MOVE: begin
						tgt_q <= cmd.direction ? diverted_q : straight_q;
					end
					srctl_pkg::ACT_CONFIGURE: begin
						straight_q <= cmd.straight_pos;
						diverted_q <= cmd.diverted_pos;
						step_q     <= cmd.step_size;
						cur_q      <= tgt_q;
					end
					srctl_pkg::ACT_TEST: begin
						tgt_q <= (cur_q < mid) ? diverted_q : straight_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign token_out = token_q;

	// The cell holding the token puts its result on the chain; others pass it on.
	always_comb begin
		if (token_q) begin
			res_out.servo_slot    = slot_id;
			res_out.pulse_value   = pulse;
			res_out.output_off    = off;
			res_out.current_value = cur_n;
			res_out.target_value  = tgt_q;
			res_out.moving        = (cur_n != tgt_q);
			res_out.last          = is_last;
		end else begin
			res_out = res_in;
		end
	end

endmodule

// File: rtl/core/servo_ramp_controller_top.sv
// Servo ramp controller for up to sixteen servos, one cell per servo in a chain.
// A tick command walks a token down the chain, one cell per cycle, and each cell
// steps its servo and hands one result to the output register; the walk stalls
// while a result waits in that register and is not taken. A configure command
// converts its three microsecond values one after another, each by a multiply
// followed by a shift and a reciprocal multiply. One command is worked on at a
// time; configuration writes are accepted in every cycle.
module servo_ramp_controller_top #(
	parameter int NUM_SERVOS = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	srctl_stream_if.sink   command,
	srctl_stream_if.source result,
	srctl_stream_if.sink   cfg_write
);

	localparam int W = srctl_pkg::POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_MUL,
		S_DIVGO,
		S_DIVWAIT,
		S_APPLY,
		S_TICK
	} state_t;

	state_t                        state_q;
	srctl_pkg::cmd_item_t          cmd_q;
	srctl_pkg::cfg_regs_t          regs_q;
	srctl_pkg::result_item_t       out_q;
	logic                          out_valid_q;
	logic [1:0]                    conv_k_q;
	logic [srctl_pkg::CONV_NUM_W-1:0] prod_q;
	logic [W-1:0]                  str_q;
	logic [W-1:0]                  div_q;
	logic [W-1:0]                  spd_q;

	logic                          advance;
	logic                          start;
	logic                          idx_ok;
	logic [srctl_pkg::US_W-1:0]    mul_op;
	logic                          div_done;
	logic [W-1:0]                  div_quot;
	srctl_pkg::chain_ctl_t         ctl;
	srctl_pkg::cell_cmd_t          cell_cmd;
	logic [NUM_SERVOS-1:0]         token;
	srctl_pkg::result_item_t       chain_res [NUM_SERVOS+1];

	function automatic logic [srctl_pkg::US_W-1:0] us_offset(
		input logic [srctl_pkg::US_W-1:0] us
	);
		logic [srctl_pkg::US_W-1:0] c;
		if (us < 16'd800) begin
			c = 16'd800;
		end else if (us > 16'd2400) begin
			c = 16'd2400;
		end else begin
			c = us;
		end
		return c - 16'd800;
	endfunction

	assign command.ready   = (state_q == S_IDLE);
	assign cfg_write.ready = 1'b1;
	assign result.valid    = out_valid_q;
	assign result.data     = out_q;

	assign advance     = (state_q == S_TICK) && (!out_valid_q || result.ready);
	assign start       = (state_q == S_DISPATCH) && (cmd_q.action == srctl_pkg::ACT_TICK);
	assign ctl.shift   = start || advance;
	assign ctl.advance = advance;
	assign idx_ok      = ({1'b0, cmd_q.servo_index} < 5'(NUM_SERVOS));

	always_comb begin
		case (conv_k_q)
			2'd0:    mul_op = us_offset(cmd_q.straight_us);
			2'd1:    mul_op = us_offset(cmd_q.diverted_us);
			default: mul_op = cmd_q.rate_us;
		endcase
	end

	// Speed divides by the span and then by 50; the two floors combine into one.
	srctl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIVGO),
		.is_speed (conv_k_q == 2'd2),
		.numer    (prod_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign cell_cmd.apply        = (state_q == S_APPLY);
	assign cell_cmd.action       = cmd_q.action;
	assign cell_cmd.servo_index  = cmd_q.servo_index;
	assign cell_cmd.direction    = cmd_q.direction;
	assign cell_cmd.straight_pos = str_q;
	assign cell_cmd.diverted_pos = div_q;
	assign cell_cmd.step_size    = (spd_q == '0) ? W'(1) : spd_q;

	assign chain_res[0] = '0;

	for (genvar i = 0; i < NUM_SERVOS; i++) begin : g_cell
		srctl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.regs      (regs_q),
			.cmd       (cell_cmd),
			.ctl       (ctl),
			.slot_id   (srctl_pkg::SLOT_W'(i)),
			.is_last   (i == NUM_SERVOS - 1),
			.token_in  ((i == 0) ? start : token[(i == 0) ? 0 : i - 1]),
			.token_out (token[i]),
			.res_in    (chain_res[i]),
			.res_out   (chain_res[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.servo_off_enable  <= 1'b1;
			regs_q.soft_start_enable <= 1'b1;
			regs_q.deadband_width    <= srctl_pkg::RESET_DEADBAND;
		end else if (cfg_write.valid) begin
			unique case (cfg_write.data.index)
				srctl_pkg::REG_SERVO_OFF:  regs_q.servo_off_enable  <= cfg_write.data.value[0];
				srctl_pkg::REG_SOFT_START: regs_q.soft_start_enable <= cfg_write.data.value[0];
				srctl_pkg::REG_DEADBAND:   regs_q.deadband_width    <= cfg_write.data.value;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			conv_k_q    <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				out_q       <= chain_res[NUM_SERVOS];
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (command.valid) begin
						cmd_q   <= command.data;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					conv_k_q <= '0;
					if (cmd_q.action == srctl_pkg::ACT_TICK) begin
						state_q <= S_TICK;
					end else if (!idx_ok) begin
						state_q <= S_IDLE;
					end else if (cmd_q.action == srctl_pkg::ACT_CONFIGURE) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_APPLY;
					end
				end
				S_MUL: begin
					prod_q  <= {12'd0, mul_op} * 28'd4095;
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIVWAIT;
				end
				S_DIVWAIT: begin
					if (div_done) begin
						case (conv_k_q)
							2'd0:    str_q <= div_quot;
							2'd1:    div_q <= div_quot;
							default: spd_q <= div_quot;
						endcase
						if (conv_k_q == 2'd2) begin
							state_q <= S_APPLY;
						end else begin
							conv_k_q <= conv_k_q + 1'b1;
							state_q  <= S_MUL;
						end
					end
				end
				S_APPLY: begin
					state_q <= S_IDLE;
				end
				S_TICK: begin
					if (advance && token[NUM_SERVOS-1]) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
